// ===== design/tftp_tc_pkg.sv =====
// Package for the TFTP transfer controller: command, action and phase codes,
// payload widths and the block size. No dependencies.
`timescale 1ns / 1ps
package tftp_tc_pkg;

    localparam int unsigned BLOCK_W = 16;
    localparam int unsigned LEN_W   = 10;
    localparam int unsigned TO_W    = 4;

    // Largest payload in one data block, in bytes.
    localparam logic [LEN_W-1:0] BLOCK_BYTES = 10'd512;

    // Register index of max_timeouts on the configuration port.
    localparam logic REG_MAX_TIMEOUTS = 1'b0;
    localparam logic [TO_W-1:0] MAX_TIMEOUTS_RST = 4'd10;

    typedef enum logic [2:0] {
        CMD_START_READ  = 3'd0,
        CMD_START_WRITE = 3'd1,
        CMD_TIMEOUT     = 3'd2,
        CMD_ACK_RX      = 3'd3,
        CMD_DATA_RX     = 3'd4,
        CMD_CHUNK_READY = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_REQUEST   = 3'd0,
        ACT_SEND_DATA = 3'd1,
        ACT_SEND_ACK  = 3'd2,
        ACT_WRITE_ACK = 3'd3,
        ACT_DONE      = 3'd4,
        ACT_FAILED    = 3'd5
    } action_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_CHUNK = 4'b0010,
        PH_ACK   = 4'b0100,
        PH_DATA  = 4'b1000
    } phase_t;

endpackage

// ===== design/tftp_transfer_controller_top.sv =====
// Top level of the lock-step TFTP transfer controller: event decode, transfer
// state and the output register. Depends on tftp_tc_pkg.
`timescale 1ns / 1ps
// Usage
// -----
// Events come in on the slave stream: s_axis_tuser carries the command and
// s_axis_tdata the block number and payload length of a received packet or
// of a chunk read from the file. Each event gives at most one request on the
// master stream: m_axis_tuser is the action, m_axis_tdata the block number
// and length to send or write, and m_axis_tlast marks the send or write that
// ends the transfer (a short block). Events that do not fit the current
// phase, or carry the wrong block, give no request at all.
// The max_timeouts register (APB, byte address 0) sets how many timeouts in
// a row fail the transfer; write it only while no transfer events are in
// flight.
// An accepted event is loaded into the input register and then decoded into
// the output register once that register is free or its request is taken.
// One event can be accepted every cycle, limited only by the output register.
// Reset leaves the controller idle with block number 1, no timeouts counted
// and max_timeouts at 10. When the receiver stalls, the pending request holds
// in the output register; the input register then fills and s_axis_tready
// drops until the request is taken.
module tftp_transfer_controller_top
(
    input  logic        clk,
    input  logic        rst_n,
    // Event stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] block_in, [25:16] length_in, rest zero
    input  logic [2:0]  s_axis_tuser,   // [2:0] cmd
    // Request stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] block_out, [25:16] length_out, rest zero
    output logic [2:0]  m_axis_tuser,   // [2:0] action
    output logic        m_axis_tlast,   // final_res
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tftp_tc_pkg::*;

    // Configuration register. Bit 2 of the byte address selects the register.
    logic [TO_W-1:0] max_timeouts_reg;
    logic            cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MAX_TIMEOUTS);
    assign prdata    = (paddr[2] == REG_MAX_TIMEOUTS) ? {28'd0, max_timeouts_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_timeouts_reg <= MAX_TIMEOUTS_RST;
        end
        else if (cfg_write)
        begin
            max_timeouts_reg <= pwdata[TO_W-1:0];
        end
    end

    // Input register. It moves on whenever the output register is free or is
    // being emptied this cycle, so a new event can enter every cycle.
    logic               in_valid_reg;
    cmd_t               in_cmd_reg;
    logic [BLOCK_W-1:0] in_block_reg;
    logic [LEN_W-1:0]   in_len_reg;
    logic               out_valid_reg;
    logic               advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cmd_reg   <= cmd_t'(s_axis_tuser);
            in_block_reg <= s_axis_tdata[15:0];
            in_len_reg   <= s_axis_tdata[25:16];
        end
    end

    // Transfer state.
    phase_t             phase_reg,         phase_next;
    logic [BLOCK_W-1:0] block_number_reg,  block_number_next;
    logic [TO_W-1:0]    timeout_count_reg, timeout_count_next;
    logic [LEN_W-1:0]   last_length_reg,   last_length_next;

    // Decode results.
    logic               res_valid;
    action_t            res_action;
    logic [BLOCK_W-1:0] res_block;
    logic [LEN_W-1:0]   res_len;
    logic               res_final;

    logic [LEN_W-1:0]   len_clamped;
    logic [TO_W-1:0]    timeout_inc;
    logic               timeout_fail;
    logic [BLOCK_W-1:0] block_plus1;

    // Lengths above one block are taken as a full block.
    assign len_clamped  = (in_len_reg > BLOCK_BYTES) ? BLOCK_BYTES : in_len_reg;
    // The timeout count saturates at its top value.
    assign timeout_inc  = (timeout_count_reg == {TO_W{1'b1}}) ? timeout_count_reg
                                                              : timeout_count_reg + 1'b1;
    assign timeout_fail = (timeout_inc >= max_timeouts_reg);
    assign block_plus1  = block_number_reg + 1'b1;

    always_comb
    begin
        phase_next         = phase_reg;
        block_number_next  = block_number_reg;
        timeout_count_next = timeout_count_reg;
        last_length_next   = last_length_reg;
        res_valid          = 1'b0;
        res_action         = ACT_REQUEST;
        res_block          = block_number_reg;
        res_len            = '0;
        res_final          = 1'b0;

        case (in_cmd_reg)
            CMD_START_READ:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    block_number_next  = 16'd1;
                    timeout_count_next = '0;
                    last_length_next   = '0;
                    phase_next         = PH_CHUNK;
                    res_valid          = 1'b1;
                    res_action         = ACT_REQUEST;
                    res_block          = 16'd1;
                end
            end
            CMD_START_WRITE:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    block_number_next  = 16'd1;
                    timeout_count_next = '0;
                    last_length_next   = '0;
                    phase_next         = PH_DATA;
                    res_valid          = 1'b1;
                    res_action         = ACT_SEND_ACK;
                    res_block          = 16'd0;
                end
            end
            CMD_TIMEOUT:
            begin
                if (phase_reg == PH_ACK || phase_reg == PH_DATA)
                begin
                    res_valid          = 1'b1;
                    timeout_count_next = timeout_inc;
                    if (timeout_fail)
                    begin
                        phase_next         = PH_IDLE;
                        timeout_count_next = '0;
                        res_action         = ACT_FAILED;
                    end
                    else if (phase_reg == PH_ACK)
                    begin
                        // Resend the block still awaiting its acknowledgement.
                        res_action = ACT_SEND_DATA;
                        res_len    = last_length_reg;
                        res_final  = (last_length_reg < BLOCK_BYTES);
                    end
                    else
                    begin
                        // Resend the last acknowledgement.
                        res_action = ACT_SEND_ACK;
                        res_block  = block_number_reg - 1'b1;
                    end
                end
            end
            CMD_ACK_RX:
            begin
                if (phase_reg == PH_ACK && in_block_reg == block_number_reg)
                begin
                    timeout_count_next = '0;
                    res_valid          = 1'b1;
                    if (last_length_reg < BLOCK_BYTES)
                    begin
                        phase_next = PH_IDLE;
                        res_action = ACT_DONE;
                    end
                    else
                    begin
                        block_number_next = block_plus1;
                        phase_next        = PH_CHUNK;
                        res_action        = ACT_REQUEST;
                        res_block         = block_plus1;
                    end
                end
            end
            CMD_DATA_RX:
            begin
                if (phase_reg == PH_DATA)
                begin
                    // Any data packet clears the count, even for the wrong block.
                    timeout_count_next = '0;
                    if (in_block_reg == block_number_reg)
                    begin
                        last_length_next  = len_clamped;
                        block_number_next = block_plus1;
                        res_valid         = 1'b1;
                        res_action        = ACT_WRITE_ACK;
                        res_len           = len_clamped;
                        res_final         = (len_clamped < BLOCK_BYTES);
                        if (len_clamped < BLOCK_BYTES)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
            end
            CMD_CHUNK_READY:
            begin
                if (phase_reg == PH_CHUNK)
                begin
                    last_length_next = len_clamped;
                    phase_next       = PH_ACK;
                    res_valid        = 1'b1;
                    res_action       = ACT_SEND_DATA;
                    res_len          = len_clamped;
                    res_final        = (len_clamped < BLOCK_BYTES);
                end
            end
            default:
            begin
                // Unused command codes are dropped.
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            block_number_reg  <= 16'd1;
            timeout_count_reg <= '0;
            last_length_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg         <= phase_next;
            block_number_reg  <= block_number_next;
            timeout_count_reg <= timeout_count_next;
            last_length_reg   <= last_length_next;
        end
    end

    // Output register.
    action_t            out_action_reg;
    logic [BLOCK_W-1:0] out_block_reg;
    logic [LEN_W-1:0]   out_len_reg;
    logic               out_final_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_action_reg <= res_action;
            out_block_reg  <= res_block;
            out_len_reg    <= res_len;
            out_final_reg  <= res_final;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_action_reg;
    assign m_axis_tdata  = {6'd0, out_len_reg, out_block_reg};
    assign m_axis_tlast  = out_final_reg;

endmodule

// ===== design/tftp_tc_chk.sv =====
// Port-level checker for the TFTP transfer controller and its bind to the top
// level. Depends on tftp_tc_pkg and tftp_transfer_controller_top.
`timescale 1ns / 1ps
module tftp_tc_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import tftp_tc_pkg::*;

    // A stalled request stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("request withdrawn while stalled");

    // Only a short data block sent or written may end the transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |->
        (m_axis_tuser == ACT_SEND_DATA || m_axis_tuser == ACT_WRITE_ACK)
        && (m_axis_tdata[25:16] < BLOCK_BYTES))
        else $error("final flag on a request that cannot end the transfer");

    // A length is carried only by data that is sent or written, never above a block.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[25:16] != 10'd0) |->
        (m_axis_tuser == ACT_SEND_DATA || m_axis_tuser == ACT_WRITE_ACK)
        && (m_axis_tdata[25:16] <= BLOCK_BYTES))
        else $error("bad length on request");

    // A full data block never ends the transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ACT_SEND_DATA || m_axis_tuser == ACT_WRITE_ACK)
        && (m_axis_tdata[25:16] == BLOCK_BYTES) |-> !m_axis_tlast)
        else $error("full block flagged as final");

endmodule

bind tftp_transfer_controller_top tftp_tc_chk u_tftp_tc_chk (.*);
